// ----- hw/rtl/periodic_timer_bank_unit_defines.svh -----
// Assertion macros for the periodic timer bank unit.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef PERIODIC_TIMER_BANK_UNIT_DEFINES_SVH
`define PERIODIC_TIMER_BANK_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PTB_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("periodic timer bank check failed");

// next-cycle implication, disabled in reset
`define PTB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("periodic timer bank check failed");

`endif

// ----- hw/rtl/ptb_pkg.sv -----
// Package for the periodic timer bank: widths, request codes, cell and sweep types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ptb_pkg;

  localparam int TIMERS_DEF = 16;
  localparam int ID_W       = 6;
  localparam int PERIOD_W   = 16;
  localparam int CNT_W      = 13;

  // period / 10 as multiply by reciprocal, exact over 16 bits
  localparam int          DIV10_SH  = 19;
  localparam logic [16:0] DIV10_MUL = 17'd52429;

  typedef enum logic [1:0] {
    REQ_TICK     = 2'd0,
    REQ_SET      = 2'd1,
    REQ_KILL     = 2'd2,
    REQ_KILL_ALL = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    SW_IDLE,
    SW_SWEEP,
    SW_FLUSH
  } sweep_state_t;

  typedef struct packed {
    logic             armed;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] limit;
    logic             reports;
  } entry_t;

  typedef struct packed {
    logic             shift;
    logic             set;
    logic             kill;
    logic             kill_all;
    logic [ID_W-1:0]  id;
    logic [CNT_W-1:0] limit;
    logic             notify;
  } cell_cmd_t;

  function automatic logic [CNT_W-1:0] limit_of(input logic [PERIOD_W-1:0] period);
    logic [PERIOD_W+17-1:0] prod;
    prod = (PERIOD_W+17)'(period) * (PERIOD_W+17)'(DIV10_MUL);
    return prod[DIV10_SH+CNT_W-1:DIV10_SH];
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/periodic_timer_bank_unit.sv -----
// Periodic timer bank top level: input decode, ring of timer cells, tick sweep.
// Depends on ptb_pkg, ptb_cell, ptb_sweep and periodic_timer_bank_unit_defines.svh.
//
// Requests enter on the s_ channel: s_tuser carries the request kind (tick, set,
// kill, kill all), s_tdata the timer id, period in ms and notify flag. Set, kill
// and kill all take effect in the cycle the beat is accepted and give no result.
// A tick starts a sweep: the timer entries rotate round a ring of TIMERS cells,
// one entry past the update stage at the ring head per cycle unless the sweep
// halts, so every timer is advanced in ascending id order. Each expiry of a
// notifying timer gives one beat on the m_ channel (m_tdata = timer id), the
// final one of the tick with m_tlast. s_tready is low from a tick's acceptance
// until its sweep is done. A result is held back until the next reporting timer
// passes the head, or until the flush state after the sweep, and is then
// registered onto m_. If m_tready is low with a result held, the sweep halts at
// the next reporting timer until the result register drains. Reset clears every
// timer, the sweep and the result register.
`timescale 1ns / 1ps
`default_nettype none
`include "periodic_timer_bank_unit_defines.svh"
module periodic_timer_bank_unit #(
  parameter int TIMERS = ptb_pkg::TIMERS_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [23:0] s_tdata,   // [5:0] timer_id, [21:6] period_ms, [22] notify, [23] zero
  input  wire  [1:0]  s_tuser,   // [1:0] req_type
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [7:0]  m_tdata,   // [5:0] fired_id, [7:6] zero
  output logic        m_tlast
);

  localparam int IdW = ptb_pkg::ID_W;
  localparam logic [IdW-1:0] MaxId = IdW'(TIMERS);

  ptb_pkg::entry_t    cell_q [TIMERS];
  ptb_pkg::entry_t    tail;
  ptb_pkg::cell_cmd_t cmd;
  logic               accept, shift, idle;
  logic [IdW-1:0]     fired_id;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = idle;

  always_comb begin
    cmd.shift    = shift;
    cmd.set      = accept && (s_tuser == ptb_pkg::REQ_SET);
    cmd.kill     = accept && (s_tuser == ptb_pkg::REQ_KILL);
    cmd.kill_all = accept && (s_tuser == ptb_pkg::REQ_KILL_ALL);
    cmd.id       = s_tdata[5:0];
    cmd.limit    = ptb_pkg::limit_of(s_tdata[21:6]);
    cmd.notify   = s_tdata[22];
  end

  for (genvar i = 0; i < TIMERS; i++) begin : g_cell
    if (i == TIMERS - 1) begin : g_tail
      ptb_cell #(.CELL_ID(IdW'(i + 1))) u_cell (
        .clk   (clk),
        .rst   (rst),
        .cmd   (cmd),
        .nb    (tail),
        .entry (cell_q[i])
      );
    end else begin : g_mid
      ptb_cell #(.CELL_ID(IdW'(i + 1))) u_cell (
        .clk   (clk),
        .rst   (rst),
        .cmd   (cmd),
        .nb    (cell_q[i+1]),
        .entry (cell_q[i])
      );
    end
  end

  ptb_sweep #(.TIMERS(TIMERS)) u_sweep (
    .clk     (clk),
    .rst     (rst),
    .start   (accept && (s_tuser == ptb_pkg::REQ_TICK)),
    .head    (cell_q[0]),
    .tail    (tail),
    .shift   (shift),
    .idle    (idle),
    .m_valid (m_tvalid),
    .m_ready (m_tready),
    .m_id    (fired_id),
    .m_last  (m_tlast)
  );

  assign m_tdata = {2'b00, fired_id};

  `PTB_ASSERT_NOW(a_fired_id_range, clk, rst, m_tvalid, (fired_id != '0) && (fired_id <= MaxId))
  `PTB_ASSERT_NEXT(a_tick_blocks_input, clk, rst, accept && (s_tuser == ptb_pkg::REQ_TICK), !s_tready)

endmodule
`default_nettype wire

// ----- hw/rtl/ptb_cell.sv -----
// One timer cell of the ring: holds a timer entry, takes its neighbour's entry on a shift.
// Depends on ptb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ptb_cell #(
  parameter logic [ptb_pkg::ID_W-1:0] CELL_ID = 1
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire ptb_pkg::cell_cmd_t cmd,
  input  wire ptb_pkg::entry_t    nb,
  output ptb_pkg::entry_t         entry
);

  logic hit;

  assign hit = (cmd.id == CELL_ID);

  always_ff @(posedge clk) begin
    if (rst || cmd.kill_all || (cmd.kill && hit)) begin
      entry <= '0;
    end else if (cmd.shift) begin
      entry <= nb;
    end else if (cmd.set && hit) begin
      entry.armed   <= 1'b1;
      entry.count   <= '0;
      entry.limit   <= cmd.limit;
      entry.reports <= cmd.notify;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/ptb_sweep.sv -----
// Tick sweep: updates the ring head each step, orders reports and drives the result register.
// Depends on ptb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ptb_sweep #(
  parameter int TIMERS = ptb_pkg::TIMERS_DEF
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      start,
  input  wire ptb_pkg::entry_t     head,
  output ptb_pkg::entry_t          tail,
  output logic                     shift,
  output logic                     idle,
  output logic                     m_valid,
  input  wire                      m_ready,
  output logic [ptb_pkg::ID_W-1:0] m_id,
  output logic                     m_last
);

  localparam int IdW   = ptb_pkg::ID_W;
  localparam int CntW  = ptb_pkg::CNT_W;
  localparam int StepW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam logic [StepW-1:0] LastStep = StepW'(TIMERS - 1);

  ptb_pkg::sweep_state_t state, state_next;
  logic [StepW-1:0] step, step_next;
  logic             p_valid, p_valid_next;
  logic [IdW-1:0]   p_id, p_id_next;
  logic             o_valid_next, o_last_next;
  logic [IdW-1:0]   o_id_next;

  logic [CntW-1:0] cnt_inc;
  logic            fire, report, out_free;

  assign cnt_inc  = head.count + CntW'(1);
  assign fire     = head.armed && (cnt_inc >= head.limit);
  assign report   = fire && head.reports;
  assign out_free = !m_valid || m_ready;
  assign idle     = (state == ptb_pkg::SW_IDLE);

  always_comb begin
    tail = head;
    if (head.armed) begin
      tail.count = fire ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ptb_pkg::SW_IDLE;
      step    <= '0;
      p_valid <= 1'b0;
      m_valid <= 1'b0;
    end else begin
      state   <= state_next;
      step    <= step_next;
      p_valid <= p_valid_next;
      m_valid <= o_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    p_id   <= p_id_next;
    m_id   <= o_id_next;
    m_last <= o_last_next;
  end

  always_comb begin
    state_next   = state;
    step_next    = step;
    p_valid_next = p_valid;
    p_id_next    = p_id;
    o_valid_next = m_valid && !m_ready;
    o_id_next    = m_id;
    o_last_next  = m_last;
    shift        = 1'b0;
    case (state)
      ptb_pkg::SW_IDLE: begin
        if (start) begin
          state_next = ptb_pkg::SW_SWEEP;
          step_next  = '0;
        end
      end
      ptb_pkg::SW_SWEEP: begin
        if (!(report && p_valid && !out_free)) begin
          shift = 1'b1;
          if (report) begin
            if (p_valid) begin
              o_valid_next = 1'b1;
              o_id_next    = p_id;
              o_last_next  = 1'b0;
            end
            p_valid_next = 1'b1;
            p_id_next    = IdW'(step) + IdW'(1);
          end
          if (step == LastStep) begin
            state_next = ptb_pkg::SW_FLUSH;
          end else begin
            step_next = step + StepW'(1);
          end
        end
      end
      ptb_pkg::SW_FLUSH: begin
        if (!p_valid) begin
          state_next = ptb_pkg::SW_IDLE;
        end else if (out_free) begin
          o_valid_next = 1'b1;
          o_id_next    = p_id;
          o_last_next  = 1'b1;
          p_valid_next = 1'b0;
          state_next   = ptb_pkg::SW_IDLE;
        end
      end
      default: begin
        state_next = ptb_pkg::SW_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- sim/tb_periodic_timer_bank_unit.sv -----
`timescale 1ns / 1ps
// Testbench for periodic_timer_bank_unit: streams tick, set and kill requests,
// predicts the expiries of every tick and checks each result beat in order.
// Depends on ptb_pkg and the block's RTL only.
module tb_periodic_timer_bank_unit;
  import ptb_pkg::*;

  localparam int TIMERS         = TIMERS_DEF;
  localparam int IDLE_PCT       = 22;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int STALL_LIMIT    = 4000;
  localparam int TAIL_CYCLES    = 3 * TIMERS + 10;

  typedef struct packed {
    req_t                kind;
    logic [ID_W-1:0]     id;
    logic [PERIOD_W-1:0] period;
    logic                notify;
    logic                drain_first;
  } request_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            last;
  } expiry_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata  = '0;   // [5:0] timer_id, [21:6] period_ms, [22] notify, [23] zero
  logic [1:0]  s_tuser  = '0;   // [1:0] req_type
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;         // [5:0] fired_id, [7:6] zero
  logic        m_tlast;

  // predicted timer bank
  logic             tmr_armed  [TIMERS];
  logic [CNT_W-1:0] tmr_count  [TIMERS];
  logic [CNT_W-1:0] tmr_limit  [TIMERS];
  logic             tmr_notify [TIMERS];

  request_t pending_q[$];
  expiry_t  expiry_q[$];
  int       n_accepted   = 0;
  int       due_left     = 0;
  int       n_fail       = 0;
  int       idle_cycles  = 0;
  int       rx_hold_at   = -1;
  int       hold_left    = 0;
  bit       rx_hold_done = 1'b0;
  int       calm_lo      = 0;
  int       calm_hi      = 0;
  bit       drain_next   = 1'b0;

  periodic_timer_bank_unit #(.TIMERS(TIMERS)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #10 clk = ~clk;

  function automatic void clear_timer(input int k);
    tmr_armed[k]  = 1'b0;
    tmr_count[k]  = '0;
    tmr_limit[k]  = '0;
    tmr_notify[k] = 1'b0;
  endfunction

  task automatic serve_request(input req_t kind, input logic [ID_W-1:0] id,
                               input logic [PERIOD_W-1:0] period, input logic notify);
    logic [TIMERS-1:0] hit;
    logic [CNT_W-1:0]  bumped;
    expiry_t           e;
    int                k;
    hit = '0;
    case (kind)
      REQ_SET: begin
        if (id >= 1 && id <= TIMERS) begin
          k = id - 1;
          tmr_armed[k]  = 1'b1;
          tmr_count[k]  = '0;
          tmr_limit[k]  = CNT_W'(period / 16'd10);
          tmr_notify[k] = notify;
        end
      end
      REQ_KILL: begin
        if (id >= 1 && id <= TIMERS) clear_timer(id - 1);
      end
      REQ_KILL_ALL: begin
        for (k = 0; k < TIMERS; k++) clear_timer(k);
      end
      default: begin
        for (k = 0; k < TIMERS; k++) begin
          if (tmr_armed[k]) begin
            bumped = tmr_count[k] + 1'b1;
            if (bumped >= tmr_limit[k]) begin
              tmr_count[k] = '0;
              hit[k] = tmr_notify[k];
            end else begin
              tmr_count[k] = bumped;
            end
          end
        end
        for (k = 0; k < TIMERS; k++) begin
          if (hit[k]) begin
            e.id   = ID_W'(k + 1);
            e.last = ((hit >> (k + 1)) == '0);
            expiry_q.push_back(e);
          end
        end
      end
    endcase
  endtask

  function automatic bit steady_phase();
    return n_accepted >= calm_lo && n_accepted < calm_hi;
  endfunction

  task automatic add_req(input req_t kind, input int id, input int period, input bit notify);
    request_t r;
    r.kind        = kind;
    r.id          = ID_W'(id);
    r.period      = PERIOD_W'(period);
    r.notify      = notify;
    r.drain_first = drain_next;
    drain_next    = 1'b0;
    pending_q.push_back(r);
  endtask

  // mostly well-formed traffic on valid ids with short periods, some noise
  task automatic add_random_req();
    int pick;
    int per;
    int bad_id;
    pick   = $urandom_range(0, 99);
    per    = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 59) : $urandom_range(0, 65535);
    bad_id = $urandom_range(0, 1) ? 0 : $urandom_range(TIMERS + 1, 63);
    if (pick < 45)
      add_req(REQ_TICK, $urandom_range(0, 63), $urandom_range(0, 65535), $urandom_range(0, 1));
    else if (pick < 78)
      add_req(REQ_SET, $urandom_range(1, TIMERS), per, $urandom_range(0, 99) < 80);
    else if (pick < 90)
      add_req(REQ_KILL, $urandom_range(1, TIMERS), $urandom_range(0, 65535),
              $urandom_range(0, 1));
    else if (pick < 93)
      add_req(REQ_KILL_ALL, $urandom_range(0, 63), $urandom_range(0, 65535),
              $urandom_range(0, 1));
    else
      add_req($urandom_range(0, 1) ? REQ_SET : REQ_KILL, bad_id, per, $urandom_range(0, 1));
  endtask

  // request driver
  always @(posedge clk) begin : feed_requests
    request_t head;
    logic     took;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      took = s_tvalid && s_tready;
      if (took) begin
        head = pending_q.pop_front();
        n_accepted <= n_accepted + 1;
      end
      if (!s_tvalid || took) begin
        if (pending_q.size() > 0 &&
            (!pending_q[0].drain_first || (!took && due_left == 0)) &&
            (steady_phase() || $urandom_range(0, 99) >= IDLE_PCT)) begin
          head = pending_q[0];
          s_tvalid <= 1'b1;
          s_tdata  <= {1'b0, head.notify, head.period, head.id};
          s_tuser  <= head.kind;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result checker and predictor
  always @(posedge clk) begin : watch_streams
    expiry_t want;
    int      k;
    if (rst) begin
      for (k = 0; k < TIMERS; k++) clear_timer(k);
    end else begin
      if (m_tvalid && m_tready) begin
        if (expiry_q.size() == 0) begin
          $error("unexpected beat: fired_id %0d last %0b", m_tdata[ID_W-1:0], m_tlast);
          n_fail++;
        end else begin
          want = expiry_q.pop_front();
          if (m_tdata[ID_W-1:0] !== want.id) begin
            $error("fired_id: expected %0d, got %0d", want.id, m_tdata[ID_W-1:0]);
            n_fail++;
          end
          if (m_tlast !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, m_tlast);
            n_fail++;
          end
        end
      end
      if (s_tvalid && s_tready)
        serve_request(req_t'(s_tuser), s_tdata[5:0], s_tdata[21:6], s_tdata[22]);
      due_left <= expiry_q.size();
    end
  end

  // receiver pacing, with one long hold-off
  always @(posedge clk) begin : pace_receiver
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (!rx_hold_done && rx_hold_at >= 0 && n_accepted >= rx_hold_at) begin
        rx_hold_done = 1'b1;
        hold_left    = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= steady_phase() || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : run_test
    int i;
    int n_total;

    // directed: empty bank, id bounds, zero and max limits, silent, re-arm, kills
    add_req(REQ_TICK, 0, 0, 0);
    add_req(REQ_SET, 1, 0, 1);
    add_req(REQ_SET, TIMERS, 9, 1);
    add_req(REQ_SET, 0, 20, 1);
    add_req(REQ_SET, TIMERS + 1, 20, 1);
    add_req(REQ_SET, 63, 65535, 1);
    add_req(REQ_SET, 2, 65535, 1);
    add_req(REQ_SET, 3, 20, 0);
    add_req(REQ_SET, 4, 30, 1);
    add_req(REQ_TICK, 63, 65535, 1);
    add_req(REQ_TICK, 5, 1234, 0);
    add_req(REQ_TICK, 0, 0, 0);
    add_req(REQ_SET, 4, 10, 1);
    add_req(REQ_TICK, 0, 0, 0);
    add_req(REQ_KILL, 1, 65535, 1);
    add_req(REQ_KILL, 0, 0, 0);
    add_req(REQ_KILL, 63, 65535, 1);
    add_req(REQ_TICK, 0, 0, 0);
    add_req(REQ_KILL_ALL, 63, 65535, 1);
    add_req(REQ_TICK, 0, 0, 0);
    add_req(REQ_SET, 5, 15, 1);
    add_req(REQ_TICK, 0, 0, 0);

    for (i = 0; i < 130; i++) add_random_req();

    // whole bank at zero limit: every tick gives the full burst
    drain_next = 1'b1;
    for (i = 1; i <= TIMERS; i++) add_req(REQ_SET, i, $urandom_range(0, 9), 1);
    rx_hold_at = pending_q.size();
    for (i = 0; i < 8; i++) add_req(REQ_TICK, $urandom_range(0, 63), 0, 0);

    calm_lo = pending_q.size();
    for (i = 0; i < 100; i++) add_random_req();
    calm_hi = pending_q.size();
    for (i = 0; i < 130; i++) add_random_req();
    n_total = pending_q.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (n_accepted < n_total) @(posedge clk);
    while (due_left != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (n_fail == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ----- periodic_timer_bank_unit.f -----
+incdir+hw/rtl
hw/rtl/ptb_pkg.sv
hw/rtl/ptb_cell.sv
hw/rtl/ptb_sweep.sv
hw/rtl/periodic_timer_bank_unit.sv
sim/tb_periodic_timer_bank_unit.sv
